@@ hdl/ipx_rip_route_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// IPX RIP route table assertion macros
// Shared concurrent assertion forms used by the route table unit.
// ----------------------------------------------------------------------------
`ifndef IPX_RIP_ROUTE_TABLE_UNIT_MACROS_SVH
`define IPX_RIP_ROUTE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPRRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPRRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/iprrt_pkg.sv @@
// ----------------------------------------------------------------------------
// IPX RIP route table package
// Payload types, register indexes, codes and constants of the route table.
// ----------------------------------------------------------------------------
package iprrt_pkg;

  localparam int unsigned RouteEntriesDefault = 32;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegInternalNet = 3'd0;
  localparam logic [CfgIdxW-1:0] RegUpMask      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIf0Net      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIf0Ticks    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIf1Net      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIf1Ticks    = 3'd5;

  // Item actions.
  localparam logic [1:0] ActInsert   = 2'd0;
  localparam logic [1:0] ActWithdraw = 2'd1;
  localparam logic [1:0] ActLookup   = 2'd2;

  // Result status codes.
  localparam logic [1:0] StNoChange = 2'd0;
  localparam logic [1:0] StSet      = 2'd1;
  localparam logic [1:0] StRemoved  = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [7:0]  DefaultTicks = 8'd99;
  localparam logic [15:0] MetricMax    = 16'hffff;
  localparam logic [7:0]  IfTicksReset = 8'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] dest_network;
    logic [31:0] via_network;
    logic [47:0] via_node;
    logic [15:0] hop_count;
    logic [15:0] tick_count;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        restart_interface;
    logic        found;
    logic [15:0] route_hops;
    logic [15:0] route_ticks;
    logic [31:0] route_via_network;
    logic [47:0] route_via_node;
  } result_t;

  typedef struct packed {
    logic [31:0] network;
    logic [15:0] hops;
    logic [15:0] ticks;
    logic [31:0] via_network;
    logic [47:0] via_node;
  } entry_t;

endpackage

@@ hdl/ipx_rip_route_table_unit.sv @@
// ----------------------------------------------------------------------------
// IPX RIP route table unit
// Distance-vector route table held in one synchronous memory, with
// insert, withdraw and lookup of routes by destination network.
// ----------------------------------------------------------------------------
// The table lives in a single-port-read, single-port-write memory of
// ROUTE_ENTRIES entries. After reset the unit clears the memory, one entry
// per cycle, and holds in_stall_o high while it does so; configuration
// writes are taken throughout. For each item the entries are then read one
// per cycle through the memory's read port to find the matching entry or
// the first free one, the scan ending early when the destination is found;
// a final state then decides and writes back once the output register can
// take the result. One item is worked on at a time; a new item may be taken
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`include "ipx_rip_route_table_unit_macros.svh"

module ipx_rip_route_table_unit #(
  parameter int unsigned ROUTE_ENTRIES = iprrt_pkg::RouteEntriesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Item channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  iprrt_pkg::item_t                    in_data_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output iprrt_pkg::result_t                  out_data_o,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [iprrt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [iprrt_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned IdxW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ROUTE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(ROUTE_ENTRIES);
  localparam logic [CntW-1:0] CntLast = CntW'(ROUTE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  // Configuration registers.
  logic [31:0] own_net_q;
  logic [1:0]  up_mask_q;
  logic [31:0] if0_net_q;
  logic [7:0]  if0_ticks_q;
  logic [31:0] if1_net_q;
  logic [7:0]  if1_ticks_q;

  state_e state_q, state_d;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IdxW-1:0]   pend_idx_q, pend_idx_d;
  logic              hit_q, hit_d;
  logic [IdxW-1:0]   match_idx_q, match_idx_d;
  logic              free_q, free_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  iprrt_pkg::entry_t ent_q, ent_d;
  iprrt_pkg::item_t  item_q, item_d;

  logic               out_valid_q, out_valid_d;
  iprrt_pkg::result_t out_q, out_d;

  // Memory ports.
  iprrt_pkg::entry_t mem [ROUTE_ENTRIES];
  iprrt_pkg::entry_t rdata_q;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  iprrt_pkg::entry_t mem_wdata;

  // Decision of the final cycle.
  iprrt_pkg::result_t res;
  logic               upd_we;
  logic [IdxW-1:0]    upd_idx;
  iprrt_pkg::entry_t  upd_entry;

  logic in_xfer;
  logic issue;
  logic out_load;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The output register can take a new result when it is empty or is being
  // emptied by a transfer in this cycle.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_net_q   <= '0;
      up_mask_q   <= '0;
      if0_net_q   <= '0;
      if0_ticks_q <= iprrt_pkg::IfTicksReset;
      if1_net_q   <= '0;
      if1_ticks_q <= iprrt_pkg::IfTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        iprrt_pkg::RegInternalNet: own_net_q   <= cfg_data_i;
        iprrt_pkg::RegUpMask:      up_mask_q   <= cfg_data_i[1:0];
        iprrt_pkg::RegIf0Net:      if0_net_q   <= cfg_data_i;
        iprrt_pkg::RegIf0Ticks:    if0_ticks_q <= cfg_data_i[7:0];
        iprrt_pkg::RegIf1Net:      if1_net_q   <= cfg_data_i;
        iprrt_pkg::RegIf1Ticks:    if1_ticks_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Route memory: one read and one write port, read data registered.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: clearing pass, scan of the table, and final update.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    ent_d       = ent_q;
    item_d      = item_q;
    issue       = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = cnt_q[IdxW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IdxW-1:0];
    mem_wdata   = '0;

    case (state_q)
      S_CLEAR: begin
        // Every entry is written to zero, which marks it free.
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          item_d  = in_data_i;
          cnt_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; its data is examined in the next cycle.
        issue      = (cnt_q != CntEnd);
        mem_re     = issue;
        pend_d     = issue;
        pend_idx_d = cnt_q[IdxW-1:0];
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (pend_q) begin
          if (rdata_q.network == item_q.dest_network) begin
            hit_d       = 1'b1;
            match_idx_d = pend_idx_q;
            ent_d       = rdata_q;
            state_d     = S_DONE;
          end else if (!free_q && (rdata_q.network == '0)) begin
            free_d     = 1'b1;
            free_idx_d = pend_idx_q;
          end
        end else if (!issue) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          mem_we    = upd_we;
          mem_waddr = upd_idx;
          mem_wdata = upd_entry;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Decision: result fields and the entry to write back, from the scan.
  // --------------------------------------------------------------------------
  always_comb begin
    logic              dest_att;
    logic [7:0]        if_ticks;
    logic [15:0]       tick_sum;
    logic              better;
    iprrt_pkg::entry_t base;
    iprrt_pkg::entry_t fresh;

    res       = '0;
    upd_we    = 1'b0;
    upd_idx   = match_idx_q;
    upd_entry = ent_q;

    dest_att = (up_mask_q[0] && (if0_net_q == item_q.dest_network)) ||
               (up_mask_q[1] && (if1_net_q == item_q.dest_network));

    // Interface one wins when both up interfaces carry the router's network.
    if_ticks = iprrt_pkg::DefaultTicks;
    if (up_mask_q[0] && (if0_net_q == item_q.via_network)) begin
      if_ticks = if0_ticks_q;
    end
    if (up_mask_q[1] && (if1_net_q == item_q.via_network)) begin
      if_ticks = if1_ticks_q;
    end
    tick_sum = item_q.tick_count + {8'd0, if_ticks};

    // A newly taken entry starts with the worst metric and no router.
    base             = ent_q;
    if (!hit_q) begin
      base.network     = item_q.dest_network;
      base.hops        = iprrt_pkg::MetricMax;
      base.ticks       = iprrt_pkg::MetricMax;
      base.via_network = '0;
      base.via_node    = '0;
    end
    better = (tick_sum < base.ticks) ||
             ((tick_sum == base.ticks) && (item_q.hop_count < base.hops));

    fresh             = base;
    fresh.hops        = item_q.hop_count;
    fresh.ticks       = tick_sum;
    fresh.via_network = item_q.via_network;
    fresh.via_node    = item_q.via_node;

    if (item_q.dest_network != '0) begin
      case (item_q.action)
        iprrt_pkg::ActLookup: begin
          if (hit_q) begin
            res.found             = 1'b1;
            res.route_hops        = ent_q.hops;
            res.route_ticks       = ent_q.ticks;
            res.route_via_network = ent_q.via_network;
            res.route_via_node    = ent_q.via_node;
          end
        end
        iprrt_pkg::ActWithdraw: begin
          if (hit_q && (item_q.dest_network != own_net_q)) begin
            res.route_hops        = ent_q.hops;
            res.route_ticks       = ent_q.ticks;
            res.route_via_network = ent_q.via_network;
            res.route_via_node    = ent_q.via_node;
            if ((ent_q.via_network == item_q.via_network) &&
                (ent_q.via_node == item_q.via_node)) begin
              upd_we                = 1'b1;
              upd_entry.network     = '0;
              res.status            = iprrt_pkg::StRemoved;
              res.restart_interface = dest_att;
            end
          end
        end
        iprrt_pkg::ActInsert: begin
          if ((item_q.dest_network != own_net_q) && !dest_att) begin
            if (!hit_q && !free_q) begin
              res.status = iprrt_pkg::StFull;
            end else begin
              upd_idx = hit_q ? match_idx_q : free_idx_q;
              if (better) begin
                upd_we     = 1'b1;
                upd_entry  = fresh;
                res.status = iprrt_pkg::StSet;
              end else begin
                // A free entry is taken even when the route is no better.
                upd_we    = !hit_q;
                upd_entry = base;
              end
              res.route_hops        = upd_entry.hops;
              res.route_ticks       = upd_entry.ticks;
              res.route_via_network = upd_entry.via_network;
              res.route_via_node    = upd_entry.via_node;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    ent_q       <= ent_d;
    item_q      <= item_d;
    out_q       <= out_d;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `IPRRT_ASSERT_NEXT(a_xfer_starts_scan, clk_i, rst_ni, in_xfer, state_q == S_SCAN, "item transfer did not start a scan")
  `IPRRT_ASSERT_IMPLY(a_write_when_allowed, clk_i, rst_ni, mem_we, (state_q == S_CLEAR) || (state_q == S_DONE), "table written outside clearing or update")
  `IPRRT_ASSERT_IMPLY(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_DONE), "result appeared without a finished item")

endmodule

@@ dv/tb_ipx_rip_route_table_unit.sv @@
// ----------------------------------------------------------------------------
// IPX RIP route table unit testbench
// Drives insert, withdraw and lookup items into the route table through a
// queued driver, mirrors every accepted item in a local route predictor and
// checks each result, field by field, against the oldest predicted route.
// ----------------------------------------------------------------------------
module tb_ipx_rip_route_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RouteEntries = iprrt_pkg::RouteEntriesDefault;
  localparam int          DestPoolSize = 64;
  localparam int          RouterPool   = 5;
  localparam int          CycleLimit   = 600000;
  localparam int          TailCycles   = RouteEntries + 8;

  // The action code that the package leaves unnamed; the block ignores it.
  localparam logic [1:0] ActUnused = 2'd3;

  // Configuration styles of the random traffic phases.
  localparam int CfgRandom = 0;
  localparam int CfgZero   = 1;
  localparam int CfgOnes   = 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           in_valid  = 1'b0;
  logic                           in_stall_o;
  iprrt_pkg::item_t               in_data   = '0;
  logic                           out_valid_o;
  logic                           out_stall = 1'b0;
  iprrt_pkg::result_t             out_data_o;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready_o;
  logic [iprrt_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [iprrt_pkg::CfgDataW-1:0] cfg_data  = '0;

  ipx_rip_route_table_unit #(
    .ROUTE_ENTRIES(RouteEntries)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Items waiting to be offered, and routes predicted for items already
  // transferred but whose results have not yet been transferred out.
  iprrt_pkg::item_t   items_pending[$];
  iprrt_pkg::result_t routes_due[$];

  // Local copy of the route table and of the interface registers.
  iprrt_pkg::entry_t route_tab[RouteEntries];
  logic [31:0] cfg_own_net   = '0;
  logic [1:0]  cfg_up_mask   = '0;
  logic [31:0] cfg_if0_net   = '0;
  logic [7:0]  cfg_if0_ticks = iprrt_pkg::IfTicksReset;
  logic [31:0] cfg_if1_net   = '0;
  logic [7:0]  cfg_if1_ticks = iprrt_pkg::IfTicksReset;

  // Pools that random traffic draws from, so that destinations recur and
  // withdraws usually name the router that last advertised the route.
  logic [31:0] dest_pool[DestPoolSize];
  int          last_router[DestPoolSize];
  logic [31:0] via_pool[RouterPool];
  logic [47:0] node_pool[RouterPool];

  // Set while one phase runs with neither side idling.
  bit steady = 1'b0;

  int mismatches     = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int n_set          = 0;
  int n_removed      = 0;
  int n_restart      = 0;
  int n_full         = 0;
  int n_found        = 0;
  int cycles         = 0;

  initial begin
    for (int s = 0; s < RouteEntries; s++) begin
      route_tab[s] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Route predictor.
  // --------------------------------------------------------------------------

  // Copies the stored metrics and router of one slot into a result.
  function automatic iprrt_pkg::result_t with_slot(input iprrt_pkg::result_t res,
                                                   input int slot);
    res.route_hops        = route_tab[slot].hops;
    res.route_ticks       = route_tab[slot].ticks;
    res.route_via_network = route_tab[slot].via_network;
    res.route_via_node    = route_tab[slot].via_node;
    return res;
  endfunction

  // Works out the result of one item and applies it to the local table.
  function automatic iprrt_pkg::result_t predict_route(input iprrt_pkg::item_t it);
    iprrt_pkg::result_t res;
    logic               attached;
    logic [15:0]        add_ticks;
    logic [15:0]        sum_ticks;
    int                 hit;
    int                 spare;
    res   = '0;
    hit   = -1;
    spare = -1;
    attached = (cfg_up_mask[0] && cfg_if0_net == it.dest_network) ||
               (cfg_up_mask[1] && cfg_if1_net == it.dest_network);
    if (it.action == ActUnused || it.dest_network == '0) begin
      return res;
    end
    // The scan stops at the slot holding the destination; the first free
    // slot seen before it is remembered for a new route.
    for (int i = 0; i < RouteEntries && hit < 0; i++) begin
      if (route_tab[i].network == it.dest_network) begin
        hit = i;
      end else if (spare < 0 && route_tab[i].network == '0) begin
        spare = i;
      end
    end
    if (it.action == iprrt_pkg::ActLookup) begin
      if (hit >= 0) begin
        res       = with_slot(res, hit);
        res.found = 1'b1;
      end
      return res;
    end
    if (it.dest_network == cfg_own_net) begin
      return res;
    end
    if (it.action == iprrt_pkg::ActWithdraw) begin
      if (hit < 0) begin
        return res;
      end
      // The slot is reported as it stood before it was freed.
      res = with_slot(res, hit);
      if (route_tab[hit].via_network == it.via_network &&
          route_tab[hit].via_node == it.via_node) begin
        route_tab[hit].network = '0;
        res.status             = iprrt_pkg::StRemoved;
        res.restart_interface  = attached;
      end
      return res;
    end
    // Insert: a route toward an attached interface that is up is ignored.
    if (attached) begin
      return res;
    end
    // Interface one wins when both interfaces sit on the router's network.
    add_ticks = {8'h00, iprrt_pkg::DefaultTicks};
    if (cfg_up_mask[0] && cfg_if0_net == it.via_network) begin
      add_ticks = {8'h00, cfg_if0_ticks};
    end
    if (cfg_up_mask[1] && cfg_if1_net == it.via_network) begin
      add_ticks = {8'h00, cfg_if1_ticks};
    end
    if (hit < 0) begin
      if (spare < 0) begin
        res.status = iprrt_pkg::StFull;
        return res;
      end
      hit                        = spare;
      route_tab[hit].network     = it.dest_network;
      route_tab[hit].hops        = iprrt_pkg::MetricMax;
      route_tab[hit].ticks       = iprrt_pkg::MetricMax;
      route_tab[hit].via_network = '0;
      route_tab[hit].via_node    = '0;
    end
    // The sum wraps at sixteen bits.
    sum_ticks = it.tick_count + add_ticks;
    if (sum_ticks < route_tab[hit].ticks ||
        (sum_ticks == route_tab[hit].ticks && it.hop_count < route_tab[hit].hops)) begin
      route_tab[hit].hops        = it.hop_count;
      route_tab[hit].ticks       = sum_ticks;
      route_tab[hit].via_network = it.via_network;
      route_tab[hit].via_node    = it.via_node;
      res.status                 = iprrt_pkg::StSet;
    end
    return with_slot(res, hit);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued items, holding each payload until its transfer.
  // The prediction is taken at the transfer itself, so it always sees the
  // register settings that the block sees.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        routes_due.push_back(predict_route(in_data));
        items_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (items_pending.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
          in_valid <= 1'b1;
          in_data  <= items_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks every result transfer and stalls the result channel at
  // random outside the steady phase.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: result %0d, %s expected %0h actual %0h",
               $time, results_seen, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input iprrt_pkg::result_t got);
    iprrt_pkg::result_t want;
    results_seen++;
    if (routes_due.size() == 0) begin
      $display("%0t: result %0d arrived with no route predicted, actual %0h",
               $time, results_seen, got);
      mismatches++;
    end else begin
      want = routes_due.pop_front();
      check_field("status", want.status, got.status);
      check_field("restart_interface", want.restart_interface, got.restart_interface);
      check_field("found", want.found, got.found);
      check_field("route_hops", want.route_hops, got.route_hops);
      check_field("route_ticks", want.route_ticks, got.route_ticks);
      check_field("route_via_network", want.route_via_network, got.route_via_network);
      check_field("route_via_node", want.route_via_node, got.route_via_node);
      case (want.status)
        iprrt_pkg::StSet:     n_set++;
        iprrt_pkg::StRemoved: n_removed++;
        iprrt_pkg::StFull:    n_full++;
        default:              ;
      endcase
      if (want.restart_interface) n_restart++;
      if (want.found) n_found++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        check_result(out_data_o);
      end
      out_stall <= !steady && ($urandom_range(99) < 13);
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: no progress after %0d cycles, %0d routes still due",
               $time, cycles, routes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Returns once nothing is queued, offered or due. Sampled on the falling
  // edge, when every update of the rising edge has settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_pending.size() != 0 || in_valid || routes_due.size() != 0);
  endtask

  // One register transfer. The valid is left high so that back-to-back
  // writes do not lower and raise it within one time step.
  task automatic write_register(input logic [iprrt_pkg::CfgIdxW-1:0] idx,
                                input logic [iprrt_pkg::CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      iprrt_pkg::RegInternalNet: cfg_own_net   = value;
      iprrt_pkg::RegUpMask:      cfg_up_mask   = value[1:0];
      iprrt_pkg::RegIf0Net:      cfg_if0_net   = value;
      iprrt_pkg::RegIf0Ticks:    cfg_if0_ticks = value[7:0];
      iprrt_pkg::RegIf1Net:      cfg_if1_net   = value;
      iprrt_pkg::RegIf1Ticks:    cfg_if1_ticks = value[7:0];
      default:                   ;
    endcase
  endtask

  // Waits until nothing is queued, offered or due, then writes every register.
  task automatic reprogram(input logic [31:0] own_net, input logic [31:0] up_mask,
                           input logic [31:0] if0_net, input logic [31:0] if0_ticks,
                           input logic [31:0] if1_net, input logic [31:0] if1_ticks);
    wait_drained();
    @(posedge clk_i);
    write_register(iprrt_pkg::RegInternalNet, own_net);
    write_register(iprrt_pkg::RegUpMask, up_mask);
    write_register(iprrt_pkg::RegIf0Net, if0_net);
    write_register(iprrt_pkg::RegIf0Ticks, if0_ticks);
    write_register(iprrt_pkg::RegIf1Net, if1_net);
    write_register(iprrt_pkg::RegIf1Ticks, if1_ticks);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_item(input logic [1:0] action, input logic [31:0] dest,
                            input logic [31:0] via, input logic [47:0] node,
                            input logic [15:0] hops, input logic [15:0] ticks);
    iprrt_pkg::item_t it;
    it.action       = action;
    it.dest_network = dest;
    it.via_network  = via;
    it.via_node     = node;
    it.hop_count    = hops;
    it.tick_count   = ticks;
    items_pending.push_back(it);
  endtask

  // Small metrics, full-range values, values near the top and the extremes,
  // so that the tick sum wraps now and then.
  function automatic logic [15:0] random_metric();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      0:       return {12'h000, r[3:0]};
      1:       return {8'h00, r[7:0]};
      2:       return r[15:0];
      3:       return iprrt_pkg::MetricMax - {8'h00, r[7:0]};
      default: return r[16] ? iprrt_pkg::MetricMax : 16'h0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_pool_dest();
    return dest_pool[$urandom_range(DestPoolSize - 1)];
  endfunction

  // One random item drawn from a window of the destination pool. Withdraws
  // usually name the router that last advertised the destination.
  function automatic iprrt_pkg::item_t random_route_item(input int base,
                                                         input int pool_size);
    iprrt_pkg::item_t it;
    int               slot;
    int               router;
    int               roll;
    logic [31:0]      r;
    slot   = (base + $urandom_range(pool_size - 1)) % DestPoolSize;
    router = $urandom_range(RouterPool - 1);
    roll   = $urandom_range(99);
    r      = $urandom;
    it.dest_network = dest_pool[slot];
    if (roll < 52) begin
      it.action         = iprrt_pkg::ActInsert;
      last_router[slot] = router;
    end else if (roll < 74) begin
      it.action = iprrt_pkg::ActWithdraw;
      if (last_router[slot] >= 0 && $urandom_range(9) < 7) router = last_router[slot];
    end else if (roll < 94) begin
      it.action = iprrt_pkg::ActLookup;
    end else if (roll < 97) begin
      it.action = ActUnused;
    end else begin
      // Network zero, the internal network and the interface networks, which the block filters out for some actions.
      it.action = (r[1:0] == ActUnused) ? iprrt_pkg::ActInsert : r[1:0];
      case ($urandom_range(3))
        0:       it.dest_network = '0;
        1:       it.dest_network = cfg_own_net;
        2:       it.dest_network = cfg_if0_net;
        default: it.dest_network = cfg_if1_net;
      endcase
    end
    it.via_network = via_pool[router];
    it.via_node    = node_pool[router];
    it.hop_count   = random_metric();
    it.tick_count  = random_metric();
    return it;
  endfunction

  // One random traffic phase: new register settings, an optional sweep that
  // withdraws every live route with its own router, then random items.
  task automatic run_traffic(input int mode, input int pool_size, input int count,
                             input bit sweep, input bit calm);
    int          base;
    logic [63:0] wide;
    logic [31:0] own_net;
    logic [31:0] if0_net;
    logic [31:0] if1_net;
    case (mode)
      CfgZero: reprogram('0, '0, '0, '0, '0, '0);
      CfgOnes: reprogram('1, '1, '1, '1, '1, '1);
      default: begin
        own_net = ($urandom_range(3) == 0) ? pick_pool_dest() : $urandom;
        if0_net = ($urandom_range(4) < 2) ? pick_pool_dest() : $urandom;
        if1_net = ($urandom_range(4) < 2) ? pick_pool_dest() : $urandom;
        reprogram(own_net, $urandom, if0_net, $urandom, if1_net, $urandom);
      end
    endcase
    steady = calm;
    // Each router sits on an attached interface's network with even odds.
    for (int r = 0; r < RouterPool; r++) begin
      wide         = {$urandom, $urandom};
      node_pool[r] = wide[47:0];
      if ($urandom_range(1) == 1) begin
        via_pool[r] = r[0] ? cfg_if1_net : cfg_if0_net;
      end else begin
        via_pool[r] = wide[63:32];
      end
    end
    for (int d = 0; d < DestPoolSize; d++) begin
      last_router[d] = -1;
    end
    // The local table is exact here, since the block has gone idle.
    if (sweep) begin
      for (int s = 0; s < RouteEntries; s++) begin
        if (route_tab[s].network != '0) begin
          queue_item(iprrt_pkg::ActWithdraw, route_tab[s].network,
                     route_tab[s].via_network, route_tab[s].via_node,
                     random_metric(), random_metric());
        end
      end
    end
    base = $urandom_range(DestPoolSize - 1);
    for (int k = 0; k < count; k++) begin
      items_pending.push_back(random_route_item(base, pool_size));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    for (int d = 0; d < DestPoolSize; d++) begin
      dest_pool[d] = $urandom;
      if (dest_pool[d] == '0) dest_pool[d] = 32'h1;
    end
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: both interfaces up, zero ticks on one, the most on the other.
    // Register writes are taken while the table is still being cleared.
    reprogram(32'h0000_1000, 32'd3, 32'h10, 32'd0, 32'h20, 32'd255);
    // Network zero, the internal network and an attached interface are
    // all ignored.
    queue_item(iprrt_pkg::ActInsert, 32'h0, 32'h30, 48'h1, 16'd1, 16'd1);
    queue_item(iprrt_pkg::ActLookup, 32'h0, 32'h30, 48'h1, 16'd1, 16'd1);
    queue_item(iprrt_pkg::ActInsert, 32'h0000_1000, 32'h30, 48'h1, 16'd1, 16'd1);
    queue_item(iprrt_pkg::ActWithdraw, 32'h0000_1000, 32'h30, 48'h1, 16'd1, 16'd1);
    queue_item(iprrt_pkg::ActInsert, 32'h10, 32'h30, 48'h1, 16'd1, 16'd1);
    // A new route, then a worse offer for it across the costly interface.
    queue_item(iprrt_pkg::ActInsert, 32'hA, 32'h10, 48'h0000_1b2c_3d4e, 16'd2, 16'd5);
    queue_item(iprrt_pkg::ActInsert, 32'hA, 32'h20, 48'h0000_5f60_7182, 16'd1, 16'd5);
    // The tick sum wraps past the top.
    queue_item(iprrt_pkg::ActInsert, 32'hB, 32'h30, 48'hffff_ffff_ffff, 16'd3, 16'hffff);
    // A new slot whose offer only equals the initial metrics stays unset;
    // one hop fewer then improves it.
    queue_item(iprrt_pkg::ActInsert, 32'hC, 32'h40, 48'h0, 16'hffff, 16'hff9c);
    queue_item(iprrt_pkg::ActInsert, 32'hC, 32'h40, 48'h0, 16'hfffe, 16'hff9c);
    queue_item(iprrt_pkg::ActLookup, 32'hA, 32'h0, 48'h0, 16'd0, 16'd0);
    queue_item(iprrt_pkg::ActLookup, 32'hD, 32'h0, 48'h0, 16'd0, 16'd0);
    // Withdraw by the wrong router keeps the route; the right one removes it.
    queue_item(iprrt_pkg::ActWithdraw, 32'hA, 32'h10, 48'h0000_5f60_7182, 16'd0, 16'd0);
    queue_item(iprrt_pkg::ActWithdraw, 32'hA, 32'h10, 48'h0000_1b2c_3d4e, 16'd0, 16'd0);
    queue_item(ActUnused, 32'hB, 32'h30, 48'hffff_ffff_ffff, 16'd3, 16'd3);
    queue_item(iprrt_pkg::ActInsert, 32'hffff_ffff, 32'hffff_ffff, 48'hffff_ffff_ffff,
               16'd0, 16'd0);
    queue_item(iprrt_pkg::ActLookup, 32'hffff_ffff, 32'h0, 48'h0, 16'hffff, 16'hffff);
    // The freed slot is reused; zero metrics are the best possible.
    queue_item(iprrt_pkg::ActInsert, 32'hD, 32'h10, 48'h0000_1b2c_3d4e, 16'd0, 16'd0);
    queue_item(iprrt_pkg::ActInsert, 32'hD, 32'h20, 48'h0000_5f60_7182, 16'd0, 16'd0);

    // With both interfaces down, their future networks enter the table.
    reprogram(32'h0000_1000, 32'd0, 32'h20, 32'd1, 32'h55, 32'd1);
    queue_item(iprrt_pkg::ActInsert, 32'h20, 32'h77, 48'h0000_0a0b_0c0d, 16'd4, 16'd4);
    queue_item(iprrt_pkg::ActInsert, 32'h55, 32'h20, 48'h0000_0a0b_0c0d, 16'd1, 16'd1);

    // Now up: removing the route to an attached network asks for a restart.
    reprogram(32'h0000_1000, 32'd3, 32'h20, 32'd7, 32'h55, 32'd200);
    queue_item(iprrt_pkg::ActWithdraw, 32'h20, 32'h77, 48'h0000_0a0b_0c0d, 16'd0, 16'd0);
    queue_item(iprrt_pkg::ActLookup, 32'h55, 32'h0, 48'h0, 16'd0, 16'd0);

    // Both interfaces on the router's network: interface one's ticks apply.
    reprogram(32'h0, 32'd3, 32'h77, 32'd3, 32'h77, 32'd9);
    queue_item(iprrt_pkg::ActInsert, 32'h123, 32'h77, 48'h0000_1b2c_3d4e, 16'd1, 16'd1);
    queue_item(iprrt_pkg::ActWithdraw, 32'hffff_ffff, 32'hffff_ffff, 48'hffff_ffff_ffff,
               16'd0, 16'd0);

    // Random traffic. Wide destination windows drive the table full; the
    // sweeps empty it again; one phase runs without any idling.
    run_traffic(CfgRandom, 44, 320, 1'b0, 1'b0);
    run_traffic(CfgZero,   16, 250, 1'b1, 1'b0);
    run_traffic(CfgOnes,   28, 300, 1'b0, 1'b1);
    run_traffic(CfgRandom, 40, 320, 1'b0, 1'b0);
    run_traffic(CfgRandom, 12, 250, 1'b1, 1'b0);
    run_traffic(CfgRandom, 56, 330, 1'b0, 1'b0);

    // Everything is in; wait for the last result and a little longer so that
    // any stray result is caught.
    wait_drained();
    steady = 1'b0;
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d items and %0d results: %0d routes set, %0d removed",
             items_accepted, results_seen, n_set, n_removed);
    $display("  (%0d with interface restart), %0d dropped on a full table, %0d lookups hit",
             n_restart, n_full, n_found);
    if (mismatches == 0 && routes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d routes never arrived", mismatches, routes_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/iprrt_pkg.sv
hdl/ipx_rip_route_table_unit.sv
dv/tb_ipx_rip_route_table_unit.sv
